// ===== rtl/pcbp_pkg.sv =====
// pcbp_pkg: shared types and constants of the prefix code bit packer
// used by pcbp_table, pcbp_pack and prefix_code_bit_packer_unit; no dependencies
`default_nettype none

package pcbp_pkg;

	localparam int WORD_BITS_DEF = 32;   // default packed word width
	localparam int CODE_BITS     = 32;   // width of a stored code
	localparam int LEN_BITS      = 6;    // width of a stored code length
	localparam int CODE_MAX_BITS = 32;   // longest code that is used
	localparam int SYM_BITS      = 8;    // symbol width
	localparam int TABLE_DEPTH   = 256;  // one entry per byte value
	localparam int OUT_BITS      = 32;   // width of the data_word port
	localparam int TOTAL_BITS    = 31;   // width of the bit counter

	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

	typedef enum logic [1:0] {
		KIND_LOAD   = 2'd0,
		KIND_ENCODE = 2'd1,
		KIND_FINISH = 2'd2
	} kind_t;

	// one code table entry
	typedef struct packed {
		logic [LEN_BITS-1:0]  len;
		logic [CODE_BITS-1:0] code;
	} entry_t;

	// control from the stage 1 register to the packing stage
	typedef struct packed {
		logic  step;   // stage 1 transaction completes this cycle
		kind_t kind;
	} pack_req_t;

endpackage

`default_nettype wire

// ===== rtl/pcbp_table.sv =====
// pcbp_table: code and length table, one write and one registered read per cycle
// depends on pcbp_pkg
`default_nettype none

module pcbp_table (
	input  wire logic                               clk,
	input  wire logic                               wr_en,
	input  wire logic [pcbp_pkg::SYM_BITS-1:0]      wr_addr,
	input  wire pcbp_pkg::entry_t                   wr_data,
	input  wire logic                               rd_en,
	input  wire logic [pcbp_pkg::SYM_BITS-1:0]      rd_addr,
	output pcbp_pkg::entry_t                        rd_data
);

	pcbp_pkg::entry_t mem [pcbp_pkg::TABLE_DEPTH];
	pcbp_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read returns the contents before this edge's write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/pcbp_pack.sv =====
// pcbp_pack: shift-merge of looked-up codes into the pending word, bit counter
// and output register; depends on pcbp_pkg
`default_nettype none

module pcbp_pack #(
	parameter int WORD_BITS = pcbp_pkg::WORD_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire pcbp_pkg::pack_req_t                  req,
	input  wire pcbp_pkg::entry_t                     entry,
	input  wire logic                                 out_stall,
	output logic                                      out_valid,
	output logic [pcbp_pkg::OUT_BITS-1:0]             data_word,
	output logic [pcbp_pkg::TOTAL_BITS-1:0]           bit_total,
	output logic                                      is_final
);

	localparam int FW   = $clog2(WORD_BITS);
	localparam int LW   = $clog2(WORD_BITS + 1);
	localparam int SW   = $clog2(2 * WORD_BITS);
	localparam int LMAX = (WORD_BITS < pcbp_pkg::CODE_MAX_BITS) ? WORD_BITS
	                                                            : pcbp_pkg::CODE_MAX_BITS;

	logic [WORD_BITS-1:0]            pending_q;
	logic [FW-1:0]                   fill_q;
	logic [pcbp_pkg::TOTAL_BITS-1:0] total_q;

	logic                            out_valid_q;
	logic [pcbp_pkg::OUT_BITS-1:0]   data_word_q;
	logic [pcbp_pkg::TOTAL_BITS-1:0] bit_total_q;
	logic                            is_final_q;

	logic [LW-1:0]                   len_c;
	logic [WORD_BITS-1:0]            len_mask;
	logic [WORD_BITS-1:0]            code_w;
	logic [WORD_BITS-1:0]            word;
	logic [WORD_BITS-1:0]            spill;
	logic [LW-1:0]                   spill_sh;
	logic [SW-1:0]                   fill_sum;
	logic                            word_full;
	logic [63:0]                     word_ext;
	logic [63:0]                     pending_ext;
	logic [pcbp_pkg::TOTAL_BITS:0]   total_sum;
	logic [pcbp_pkg::TOTAL_BITS-1:0] total_next;

	always_comb begin
		// clamp long lengths and drop stray code bits
		if (entry.len > pcbp_pkg::LEN_BITS'(LMAX)) begin
			len_c = LW'(LMAX);
		end else begin
			len_c = LW'(entry.len);
		end
		len_mask  = ~({WORD_BITS{1'b1}} << len_c);
		code_w    = WORD_BITS'(entry.code) & len_mask;
		word      = pending_q | (code_w << fill_q);
		fill_sum  = SW'(fill_q) + SW'(len_c);
		word_full = fill_sum >= SW'(WORD_BITS);
		spill_sh  = LW'(WORD_BITS) - LW'(fill_q);
		if (fill_q == '0) begin
			spill = '0;
		end else begin
			spill = code_w >> spill_sh;
		end
		word_ext    = 64'(word);
		pending_ext = 64'(pending_q);
		total_sum   = {1'b0, total_q} + (pcbp_pkg::TOTAL_BITS + 1)'(len_c);
		if (total_sum > {1'b0, pcbp_pkg::TOTAL_MAX}) begin
			total_next = pcbp_pkg::TOTAL_MAX;
		end else begin
			total_next = total_sum[pcbp_pkg::TOTAL_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			fill_q    <= '0;
			total_q   <= '0;
		end else if (req.step) begin
			unique case (req.kind)
				pcbp_pkg::KIND_ENCODE: begin
					total_q <= total_next;
					if (word_full) begin
						pending_q <= spill;
						fill_q    <= FW'(fill_sum - SW'(WORD_BITS));
					end else begin
						pending_q <= word;
						fill_q    <= FW'(fill_sum);
					end
				end
				pcbp_pkg::KIND_FINISH: begin
					pending_q <= '0;
					fill_q    <= '0;
					total_q   <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (req.step && req.kind == pcbp_pkg::KIND_ENCODE && word_full) begin
			out_valid_q <= 1'b1;
		end else if (req.step && req.kind == pcbp_pkg::KIND_FINISH) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.step && req.kind == pcbp_pkg::KIND_ENCODE && word_full) begin
			data_word_q <= word_ext[pcbp_pkg::OUT_BITS-1:0];
			bit_total_q <= '0;
			is_final_q  <= 1'b0;
		end else if (req.step && req.kind == pcbp_pkg::KIND_FINISH) begin
			data_word_q <= pending_ext[pcbp_pkg::OUT_BITS-1:0];
			bit_total_q <= total_q;
			is_final_q  <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign data_word = data_word_q;
	assign bit_total = bit_total_q;
	assign is_final  = is_final_q;

endmodule

`default_nettype wire

// ===== rtl/prefix_code_bit_packer_unit.sv =====
// prefix_code_bit_packer_unit: top level of the prefix code bit packer
// a result passes from its input transaction through the stage 1 register and table read into the output register
// throughput: one transaction per cycle unless the output stalls, set by the registered table read and shift-merge
// a stalled output holds back the input only once a result-producing transaction is waiting
// reset (arst_n low, asynchronous) clears pending word, fill count, bit total and valids
// table contents are undefined after reset until loaded; no clearing pass
`default_nettype none

module prefix_code_bit_packer_unit #(
	parameter int WORD_BITS = pcbp_pkg::WORD_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// input channel
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [1:0]                           kind,
	input  wire logic [pcbp_pkg::SYM_BITS-1:0]        symbol,
	input  wire logic [pcbp_pkg::CODE_BITS-1:0]       code_value,
	input  wire logic [pcbp_pkg::LEN_BITS-1:0]        code_length,
	// output channel
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [pcbp_pkg::OUT_BITS-1:0]             data_word,
	output logic [pcbp_pkg::TOTAL_BITS-1:0]           bit_total,
	output logic                                      is_final
);

	// stage 1 holds the transaction while the table read is in flight
	logic                valid_s1;
	pcbp_pkg::kind_t     kind_s1;

	logic                in_accept;
	logic                adv_s1;
	logic                makes_result_s1;
	pcbp_pkg::kind_t     kind_in;
	pcbp_pkg::entry_t    wr_entry;
	pcbp_pkg::entry_t    rd_entry;
	pcbp_pkg::pack_req_t req;

	assign kind_in = pcbp_pkg::kind_t'(kind);

	// encode may fill a word, finish always emits; both need room in the output register
	assign makes_result_s1 = (kind_s1 == pcbp_pkg::KIND_ENCODE) ||
	                         (kind_s1 == pcbp_pkg::KIND_FINISH);
	assign adv_s1    = valid_s1 && (!makes_result_s1 || !out_valid || !out_stall);
	assign in_stall  = valid_s1 && !adv_s1;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_s1 <= kind_in;
		end
	end

	// loads write the table at acceptance; a following encode reads at its own, later acceptance
	// and so always sees the new entry, which removes any need for forwarding
	assign wr_entry.len  = code_length;
	assign wr_entry.code = code_value;

	pcbp_table u_table (
		.clk     (clk),
		.wr_en   (in_accept && kind_in == pcbp_pkg::KIND_LOAD),
		.wr_addr (symbol),
		.wr_data (wr_entry),
		.rd_en   (in_accept),
		.rd_addr (symbol),
		.rd_data (rd_entry)
	);

	assign req.step = adv_s1;
	assign req.kind = kind_s1;

	// shift-merge, saturating bit count and output register
	pcbp_pack #(
		.WORD_BITS (WORD_BITS)
	) u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.entry     (rd_entry),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.data_word (data_word),
		.bit_total (bit_total),
		.is_final  (is_final)
	);

	// input is held back only by a waiting result-producing transaction
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled without a blocked output");

	// an empty output register never holds back the input
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output register empty");

	// full words carry no bit total
	a_total_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_final) |-> (bit_total == '0))
		else $error("bit total on a non-final word");

endmodule

`default_nettype wire

// ===== test/prefix_code_bit_packer_unit_tb.sv =====
// prefix_code_bit_packer_unit_tb: self-checking bench for the prefix code bit packer
// drives load, encode, finish and unused transactions with random bursts and stalls,
// predicts every packed word in-bench; depends on pcbp_pkg and prefix_code_bit_packer_unit
`default_nettype none

module prefix_code_bit_packer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pcbp_pkg::*;

	localparam int WORD_BITS = WORD_BITS_DEF;
	localparam logic [63:0] WORD_MASK = (WORD_BITS >= 64) ? {64{1'b1}} :
		((64'd1 << WORD_BITS) - 64'd1);
	localparam logic [1:0] KIND_UNUSED = 2'd3;   // ignored by the block
	localparam int RANDOM_ITEMS   = 700;
	localparam int HOLDOFF_CYCLES = 250;          // long receiver hold-off
	localparam int HOLDOFF_COUNT  = 2;
	localparam int IDLE_LIMIT     = 2000;         // cycles without any transaction
	localparam int DRAIN_CYCLES   = 8;            // run-on after the last expected word
	localparam int REPORT_LIMIT   = 10;

	// one input transaction
	typedef struct packed {
		logic [1:0]           kind;
		logic [SYM_BITS-1:0]  symbol;
		logic [CODE_BITS-1:0] code_value;
		logic [LEN_BITS-1:0]  code_length;
	} pack_item_t;

	// one output transaction
	typedef struct packed {
		logic [OUT_BITS-1:0]   data_word;
		logic [TOTAL_BITS-1:0] bit_total;
		logic                  is_final;
	} packed_word_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	initial forever #6 clk = ~clk;

	// block ports, all known from time zero
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic [1:0]            kind        = KIND_LOAD;
	logic [SYM_BITS-1:0]   symbol      = '0;
	logic [CODE_BITS-1:0]  code_value  = '0;
	logic [LEN_BITS-1:0]   code_length = '0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic [OUT_BITS-1:0]   data_word;
	logic [TOTAL_BITS-1:0] bit_total;
	logic                  is_final;

	prefix_code_bit_packer_unit #(
		.WORD_BITS(WORD_BITS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.symbol     (symbol),
		.code_value (code_value),
		.code_length(code_length),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.data_word  (data_word),
		.bit_total  (bit_total),
		.is_final   (is_final)
	);

	// ------------------------------------------------------------------
	// packing predictor: own copy of the code table and the packer state
	// ------------------------------------------------------------------
	logic [CODE_BITS-1:0]  code_store   [TABLE_DEPTH];
	logic [LEN_BITS-1:0]   length_store [TABLE_DEPTH];
	logic [63:0]           acc_word    = '0;
	int unsigned           acc_fill    = 0;
	logic [TOTAL_BITS-1:0] stream_bits = '0;

	packed_word_t expected_words[$];

	// work out the word, if any, that one accepted transaction produces
	function automatic void predict_packing(input pack_item_t item);
		int unsigned  use_len;
		int unsigned  fill;
		longint       sum;
		logic [63:0]  code;
		logic [63:0]  merged;
		packed_word_t word;
		case (item.kind)
			KIND_LOAD: begin
				code_store[item.symbol]   = item.code_value;
				length_store[item.symbol] = item.code_length;
			end
			KIND_ENCODE: begin
				use_len = length_store[item.symbol];
				// long lengths are clamped, stray bits above the length dropped
				if (use_len > CODE_MAX_BITS)
					use_len = CODE_MAX_BITS;
				if (use_len > WORD_BITS)
					use_len = WORD_BITS;
				code = {32'd0, code_store[item.symbol]} & ((64'd1 << use_len) - 64'd1);
				// bit total saturates rather than wrapping
				sum = longint'(stream_bits) + longint'(use_len);
				if (sum > longint'(TOTAL_MAX))
					stream_bits = TOTAL_MAX;
				else
					stream_bits = sum[TOTAL_BITS-1:0];
				fill   = acc_fill % WORD_BITS;
				merged = (acc_word | (code << fill)) & WORD_MASK;
				if (fill + use_len < WORD_BITS) begin
					acc_word = merged;
					acc_fill = fill + use_len;
				end else begin
					// word complete: high code bits that did not fit open the next word
					acc_word = (fill == 0) ? 64'd0 : ((code >> (WORD_BITS - fill)) & WORD_MASK);
					acc_fill = fill + use_len - WORD_BITS;
					word.data_word = merged[OUT_BITS-1:0];
					word.bit_total = '0;
					word.is_final  = 1'b0;
					expected_words.push_back(word);
				end
			end
			KIND_FINISH: begin
				// always one word, even an empty one
				word.data_word = acc_word[OUT_BITS-1:0];
				word.bit_total = stream_bits;
				word.is_final  = 1'b1;
				expected_words.push_back(word);
				acc_word    = '0;
				acc_fill    = 0;
				stream_bits = '0;
			end
			default: begin
				// unused kind: no word, no state change
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// stimulus store, filled up front by the initial block
	// ------------------------------------------------------------------
	pack_item_t pending_items[$];
	logic       entry_loaded [TABLE_DEPTH];
	logic [SYM_BITS-1:0] loaded_syms[$];
	int         stimulus_items = 0;   // transactions that count, unused kind excluded

	function automatic void add_load(input logic [SYM_BITS-1:0] sym,
	                                 input logic [CODE_BITS-1:0] code,
	                                 input logic [LEN_BITS-1:0] len);
		pack_item_t item;
		item = '{kind: KIND_LOAD, symbol: sym, code_value: code, code_length: len};
		pending_items.push_back(item);
		stimulus_items++;
		if (!entry_loaded[sym]) begin
			entry_loaded[sym] = 1'b1;
			loaded_syms.push_back(sym);
		end
	endfunction

	// only symbols whose entry has been written are ever encoded
	function automatic void add_encode(input logic [SYM_BITS-1:0] sym);
		pack_item_t item;
		item = '{kind: KIND_ENCODE, symbol: sym, code_value: $urandom,
		         code_length: LEN_BITS'($urandom)};
		pending_items.push_back(item);
		stimulus_items++;
	endfunction

	function automatic void add_finish();
		pack_item_t item;
		item = '{kind: KIND_FINISH, symbol: SYM_BITS'($urandom), code_value: $urandom,
		         code_length: LEN_BITS'($urandom)};
		pending_items.push_back(item);
		stimulus_items++;
	endfunction

	function automatic void add_unused(input logic [CODE_BITS-1:0] code);
		pack_item_t item;
		item = '{kind: KIND_UNUSED, symbol: SYM_BITS'($urandom), code_value: code,
		         code_length: LEN_BITS'($urandom)};
		pending_items.push_back(item);
	endfunction

	// mostly ordinary lengths, some zero, some beyond the clamp
	function automatic logic [LEN_BITS-1:0] random_length();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			return '0;
		else if (pick < 12)
			return LEN_BITS'($urandom_range(CODE_MAX_BITS + 1, (1 << LEN_BITS) - 1));
		else if (pick < 50)
			return LEN_BITS'($urandom_range(1, 8));
		else
			return LEN_BITS'($urandom_range(1, CODE_MAX_BITS));
	endfunction

	// ------------------------------------------------------------------
	// sender: bursts of random length with random gaps, payload held while stalled
	// ------------------------------------------------------------------
	pack_item_t  next_item;
	int unsigned burst_left      = 0;
	int unsigned gap_left        = 0;
	int          accepted_items  = 0;
	int          in_stall_cycles = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			kind        <= KIND_LOAD;
			symbol      <= '0;
			code_value  <= '0;
			code_length <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_packing('{kind: kind, symbol: symbol, code_value: code_value,
				                  code_length: code_length});
				accepted_items <= accepted_items + 1;
			end
			if (in_valid && in_stall)
				in_stall_cycles <= in_stall_cycles + 1;
			// a new transaction only once the current one has gone
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					next_item   = pending_items.pop_front();
					in_valid    <= 1'b1;
					kind        <= next_item.kind;
					symbol      <= next_item.symbol;
					code_value  <= next_item.code_value;
					code_length <= next_item.code_length;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 40);
						// a third of the bursts run straight on
						gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver: stall pattern in phases, plus long hold-offs that fill the block
	// ------------------------------------------------------------------
	int unsigned holdoff_left     = 0;
	int          holdoffs_done    = 0;
	int unsigned stall_mode       = 0;
	int unsigned stall_phase_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (holdoff_left != 0) begin
			holdoff_left <= holdoff_left - 1;
			out_stall    <= 1'b1;
		end else if (holdoffs_done < HOLDOFF_COUNT &&
		             accepted_items >= 150 + 300 * holdoffs_done) begin
			// sender keeps offering while the output is blocked
			holdoff_left  <= HOLDOFF_CYCLES;
			holdoffs_done <= holdoffs_done + 1;
			out_stall     <= 1'b1;
		end else begin
			if (stall_phase_left == 0) begin
				stall_mode       <= $urandom_range(0, 2);
				stall_phase_left <= $urandom_range(8, 60);
			end else begin
				stall_phase_left <= stall_phase_left - 1;
			end
			case (stall_mode)
				0:       out_stall <= 1'b0;
				1:       out_stall <= ($urandom_range(0, 99) < 30);
				default: out_stall <= ($urandom_range(0, 99) < 75);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// monitor: every output transaction against the oldest expected word
	// ------------------------------------------------------------------
	packed_word_t oldest_word;
	int fail_count   = 0;
	int full_words   = 0;
	int final_words  = 0;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				if (fail_count < REPORT_LIMIT)
					$display("unexpected word: data_word=%h bit_total=%0d is_final=%0b",
					         data_word, bit_total, is_final);
				fail_count <= fail_count + 1;
			end else begin
				oldest_word = expected_words.pop_front();
				if (data_word !== oldest_word.data_word ||
				    bit_total !== oldest_word.bit_total ||
				    is_final  !== oldest_word.is_final) begin
					if (fail_count < REPORT_LIMIT) begin
						$display("word mismatch: expected data_word=%h bit_total=%0d is_final=%0b",
						         oldest_word.data_word, oldest_word.bit_total,
						         oldest_word.is_final);
						$display("               got      data_word=%h bit_total=%0d is_final=%0b",
						         data_word, bit_total, is_final);
					end
					fail_count <= fail_count + 1;
				end
				if (oldest_word.is_final)
					final_words <= final_words + 1;
				else
					full_words <= full_words + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog: too long without a transaction on either side
	// ------------------------------------------------------------------
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transaction for %0d cycles, %0d words outstanding",
				         IDLE_LIMIT, expected_words.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus, reset and end of run
	// ------------------------------------------------------------------
	initial begin : stimulus_and_end
		int unsigned stream_len;
		int unsigned reloads;
		int unsigned pick;
		int          target;

		foreach (entry_loaded[i])
			entry_loaded[i] = 1'b0;

		// directed: empty stream, unused kind, field extremes and the corner cases
		add_finish();                                  // empty stream gives a zero word
		add_unused({CODE_BITS{1'b1}});
		add_load(8'd0,   32'hFFFF_FFFF, 6'd32);        // full-width code
		add_load(8'd255, 32'h0000_0000, 6'd1);
		add_load(8'd1,   32'hA5A5_A5A5, 6'd0);         // zero length adds nothing
		add_load(8'd2,   32'hFFFF_FFFF, 6'd63);        // long length, clamped
		add_load(8'd3,   32'hFFFF_FFFD, 6'd3);         // stray bits above the length
		add_load(8'h80,  32'h1234_5678, 6'd17);
		add_encode(8'd0);                              // full word straight from empty
		add_encode(8'd3);
		add_encode(8'd0);                              // spills into the next word
		add_encode(8'd1);
		add_encode(8'd2);
		add_encode(8'd255);
		add_encode(8'h80);
		add_finish();                                  // partial final word
		add_encode(8'h80);
		add_encode(8'h80);
		add_encode(8'd3);
		add_unused(32'd0);
		add_finish();

		// random: well-formed streams with the odd reload, stray transaction and run-on
		target = stimulus_items + RANDOM_ITEMS;
		while (stimulus_items < target) begin
			reloads = $urandom_range(0, 6);
			repeat (reloads)
				add_load(SYM_BITS'($urandom), $urandom, random_length());
			stream_len = $urandom_range(1, 40);
			repeat (stream_len) begin
				pick = $urandom_range(0, 99);
				if (pick < 4)
					add_unused($urandom);
				else if (pick < 9)
					add_load(SYM_BITS'($urandom), $urandom, random_length());
				else
					add_encode(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
			end
			// now and then a stream runs on into the next one
			if ($urandom_range(0, 9) != 0)
				add_finish();
		end
		add_finish();

		// hold reset, then release it; the bench then runs by itself
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d input transactions (%0d of unused kind), %0d table entries",
		         accepted_items, accepted_items - stimulus_items, loaded_syms.size());
		$display("checked %0d full and %0d final words; input held off %0d cycles",
		         full_words, final_words, in_stall_cycles);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d failures", fail_count);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire
